// ===== hw/rtl/bezier_point_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// Bezier point sampler assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_SAMPLER_ASSERT_SVH
`define BEZIER_POINT_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BZS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bezier point sampler: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BZS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bezier point sampler: next-cycle check failed");

`endif

// ===== hw/rtl/bzs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier point sampler package
// Widths, pipeline stage positions, shared types and the rounding helper.
// ----------------------------------------------------------------------------
package bzs_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int T_FRAC_BITS = 16;
   localparam int CNT_WIDTH   = 8;

   localparam logic [CNT_WIDTH-1:0] CNT_RESET = CNT_WIDTH'(100);

   localparam logic OP_QUADRATIC = 1'b0;
   localparam logic OP_CUBIC     = 1'b1;

   localparam int U_WIDTH    = T_FRAC_BITS + 1;
   localparam int PROD_WIDTH = 2 * U_WIDTH;
   localparam int W_WIDTH    = T_FRAC_BITS + 3;
   localparam int TERM_WIDTH = W_WIDTH + 1 + COORD_WIDTH;
   localparam int SUM_WIDTH  = TERM_WIDTH + 2;

   localparam int DIV_HI_BITS = T_FRAC_BITS / 2;
   localparam int DIV_LO_BITS = T_FRAC_BITS - DIV_HI_BITS;

   localparam int ST_CLAMP   = 0;
   localparam int ST_DIV_A   = 1;
   localparam int ST_DIV_B   = 2;
   localparam int ST_U       = 3;
   localparam int ST_SQ      = 4;
   localparam int ST_WT      = 5;
   localparam int ST_MUL     = 6;
   localparam int ST_SUM     = 7;
   localparam int ST_OUT     = 8;
   localparam int NUM_STAGES = 9;

   localparam logic [PROD_WIDTH-1:0] PROD_HALF = PROD_WIDTH'(1) << (T_FRAC_BITS - 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [NUM_STAGES-1:0] stage_en_type;

   typedef struct packed {
      logic      operation;
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
      coord_type handle_one_x;
      coord_type handle_one_y;
      coord_type handle_two_x;
      coord_type handle_two_y;
   } points_type;

   typedef struct packed {
      logic [W_WIDTH-1:0] ws;
      logic [W_WIDTH-1:0] wa;
      logic [W_WIDTH-1:0] wb;
      logic [W_WIDTH-1:0] we;
   } weights_type;

   function automatic logic [U_WIDTH-1:0] rnd_prod(input logic [PROD_WIDTH-1:0] p);
      logic [PROD_WIDTH-1:0] sum;
      sum = p + PROD_HALF;
      return sum[T_FRAC_BITS +: U_WIDTH];
   endfunction

endpackage

// ===== hw/rtl/bzs_if.sv =====
// ----------------------------------------------------------------------------
// Bezier point sampler channels
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bzs_req_if;
   import bzs_pkg::*;

   logic      valid;
   logic      ready;
   logic      operation;
   coord_type start_x;
   coord_type start_y;
   coord_type end_x;
   coord_type end_y;
   coord_type handle_one_x;
   coord_type handle_one_y;
   coord_type handle_two_x;
   coord_type handle_two_y;
   logic [CNT_WIDTH-1:0] sample_index;

   modport source (
      output valid, operation, start_x, start_y, end_x, end_y,
             handle_one_x, handle_one_y, handle_two_x, handle_two_y, sample_index,
      input  ready
   );

   modport sink (
      input  valid, operation, start_x, start_y, end_x, end_y,
             handle_one_x, handle_one_y, handle_two_x, handle_two_y, sample_index,
      output ready
   );
endinterface

interface bzs_rsp_if;
   import bzs_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;

   modport source (output valid, point_x, point_y, input ready);
   modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface bzs_csr_if;
   import bzs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CNT_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/bzs_divider.sv =====
// ----------------------------------------------------------------------------
// Bezier point sampler divider
// Two-stage restoring division that forms t = floor(i * 2^T / count).
// ----------------------------------------------------------------------------
module bzs_divider (
   input  logic                           clock,
   input  bzs_pkg::stage_en_type          en,
   input  logic [bzs_pkg::CNT_WIDTH-1:0]  idx,
   input  logic [bzs_pkg::CNT_WIDTH-1:0]  cnt,
   output logic [bzs_pkg::T_FRAC_BITS-1:0] t
);
   import bzs_pkg::*;

   logic [CNT_WIDTH-1:0]   rem_a_in, rem_a_ff;
   logic [CNT_WIDTH-1:0]   cnt_a_ff;
   logic [DIV_HI_BITS-1:0] q_a_in, q_a_ff;
   logic [CNT_WIDTH:0]     step_a;

   logic [CNT_WIDTH-1:0]   rem_b;
   logic [DIV_LO_BITS-1:0] q_b;
   logic [CNT_WIDTH:0]     step_b;
   logic [T_FRAC_BITS-1:0] t_in, t_ff;

   // The index is already below the count, so the remainder starts there.
   always_comb begin
      rem_a_in = idx;
      q_a_in   = '0;
      step_a   = '0;
      for (int k = 0; k < DIV_HI_BITS; k++) begin
         step_a = {rem_a_in, 1'b0};
         if (step_a >= {1'b0, cnt}) begin
            rem_a_in                  = CNT_WIDTH'(step_a - {1'b0, cnt});
            q_a_in[DIV_HI_BITS-1-k] = 1'b1;
         end else begin
            rem_a_in = CNT_WIDTH'(step_a);
         end
      end
   end

   always_comb begin
      rem_b  = rem_a_ff;
      q_b    = '0;
      step_b = '0;
      for (int k = 0; k < DIV_LO_BITS; k++) begin
         step_b = {rem_b, 1'b0};
         if (step_b >= {1'b0, cnt_a_ff}) begin
            rem_b                  = CNT_WIDTH'(step_b - {1'b0, cnt_a_ff});
            q_b[DIV_LO_BITS-1-k] = 1'b1;
         end else begin
            rem_b = CNT_WIDTH'(step_b);
         end
      end
      t_in = {q_a_ff, q_b};
   end

   always_ff @(posedge clock) begin
      if (en[ST_DIV_A]) begin
         rem_a_ff <= rem_a_in;
         q_a_ff   <= q_a_in;
         cnt_a_ff <= cnt;
      end
      if (en[ST_DIV_B]) begin
         t_ff <= t_in;
      end
   end

   assign t = t_ff;

endmodule

// ===== hw/rtl/bzs_weight.sv =====
// ----------------------------------------------------------------------------
// Bezier point sampler weights
// Three stages that turn t into the Bernstein weights of a quadratic or
// cubic curve, each product rounded to the fraction width.
// ----------------------------------------------------------------------------
module bzs_weight (
   input  logic                            clock,
   input  bzs_pkg::stage_en_type           en,
   input  logic [bzs_pkg::T_FRAC_BITS-1:0] t,
   input  logic                            operation,
   output bzs_pkg::weights_type            weights
);
   import bzs_pkg::*;

   localparam logic [U_WIDTH-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   logic [U_WIDTH-1:0] u4_in, u4_ff, t4_ff;

   logic [U_WIDTH-1:0] uu5_in, ut5_in, tt5_in;
   logic [U_WIDTH-1:0] uu5_ff, ut5_ff, tt5_ff, u5_ff, t5_ff;

   logic [U_WIDTH-1:0] c0, c1, c2, c3;
   weights_type        w_in, w_ff;

   assign u4_in = ONE - {1'b0, t};

   assign uu5_in = rnd_prod(PROD_WIDTH'(u4_ff) * PROD_WIDTH'(u4_ff));
   assign ut5_in = rnd_prod(PROD_WIDTH'(u4_ff) * PROD_WIDTH'(t4_ff));
   assign tt5_in = rnd_prod(PROD_WIDTH'(t4_ff) * PROD_WIDTH'(t4_ff));

   assign c0 = rnd_prod(PROD_WIDTH'(uu5_ff) * PROD_WIDTH'(u5_ff));
   assign c1 = rnd_prod(PROD_WIDTH'(uu5_ff) * PROD_WIDTH'(t5_ff));
   assign c2 = rnd_prod(PROD_WIDTH'(u5_ff) * PROD_WIDTH'(tt5_ff));
   assign c3 = rnd_prod(PROD_WIDTH'(tt5_ff) * PROD_WIDTH'(t5_ff));

   // A quadratic curve gives the second handle no weight.
   always_comb begin
      if (operation == OP_CUBIC) begin
         w_in.ws = W_WIDTH'(c0);
         w_in.wa = (W_WIDTH'(c1) << 1) + W_WIDTH'(c1);
         w_in.wb = (W_WIDTH'(c2) << 1) + W_WIDTH'(c2);
         w_in.we = W_WIDTH'(c3);
      end else begin
         w_in.ws = W_WIDTH'(uu5_ff);
         w_in.wa = W_WIDTH'(ut5_ff) << 1;
         w_in.wb = '0;
         w_in.we = W_WIDTH'(tt5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_U]) begin
         u4_ff <= u4_in;
         t4_ff <= {1'b0, t};
      end
      if (en[ST_SQ]) begin
         uu5_ff <= uu5_in;
         ut5_ff <= ut5_in;
         tt5_ff <= tt5_in;
         u5_ff  <= u4_ff;
         t5_ff  <= t4_ff;
      end
      if (en[ST_WT]) begin
         w_ff <= w_in;
      end
   end

   assign weights = w_ff;

endmodule

// ===== hw/rtl/bzs_blend.sv =====
// ----------------------------------------------------------------------------
// Bezier point sampler blend
// Weighted sum of the four control coordinates of one axis, then rounding
// to nearest and saturation, over three stages.
// ----------------------------------------------------------------------------
module bzs_blend (
   input  logic                   clock,
   input  bzs_pkg::stage_en_type  en,
   input  bzs_pkg::weights_type   weights,
   input  bzs_pkg::coord_type     start_c,
   input  bzs_pkg::coord_type     handle_one_c,
   input  bzs_pkg::coord_type     handle_two_c,
   input  bzs_pkg::coord_type     end_c,
   output bzs_pkg::coord_type     point
);
   import bzs_pkg::*;

   localparam logic signed [SUM_WIDTH-1:0] SUM_HALF = SUM_WIDTH'(1) << (T_FRAC_BITS - 1);
   localparam logic signed [SUM_WIDTH-1:0] SAT_HI =
      {{(SUM_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SAT_LO = -SAT_HI - SUM_WIDTH'(1);

   logic signed [TERM_WIDTH-1:0] term_in [4];
   logic signed [TERM_WIDTH-1:0] term_ff [4];
   logic signed [SUM_WIDTH-1:0]  sum_in, sum_ff;
   logic signed [SUM_WIDTH-1:0]  rounded, shifted;
   coord_type                    point_in, point_ff;

   assign term_in[0] = $signed({1'b0, weights.ws}) * start_c;
   assign term_in[1] = $signed({1'b0, weights.wa}) * handle_one_c;
   assign term_in[2] = $signed({1'b0, weights.wb}) * handle_two_c;
   assign term_in[3] = $signed({1'b0, weights.we}) * end_c;

   assign sum_in = SUM_WIDTH'(term_ff[0]) + SUM_WIDTH'(term_ff[1])
                 + SUM_WIDTH'(term_ff[2]) + SUM_WIDTH'(term_ff[3]);

   assign rounded = sum_ff + SUM_HALF;
   assign shifted = rounded >>> T_FRAC_BITS;

   always_comb begin
      if (shifted > SAT_HI) begin
         point_in = coord_type'(SAT_HI[COORD_WIDTH-1:0]);
      end else if (shifted < SAT_LO) begin
         point_in = coord_type'(SAT_LO[COORD_WIDTH-1:0]);
      end else begin
         point_in = coord_type'(shifted[COORD_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         term_ff <= term_in;
      end
      if (en[ST_SUM]) begin
         sum_ff <= sum_in;
      end
      if (en[ST_OUT]) begin
         point_ff <= point_in;
      end
   end

   assign point = point_ff;

endmodule

// ===== hw/rtl/bezier_point_sampler.sv =====
// ----------------------------------------------------------------------------
// Bezier point sampler
// One point on a quadratic or cubic Bezier curve for each request beat.
//
//   channel  role   beat contents
//   req_ch   sink   operation, anchors, handles, sample_index
//   rsp_ch   source point_x, point_y
//   csr_ch   sink   segment_count
//
// A beat enters in every cycle that req_ch.ready is high, and the
// nine register stages are clamp, two divider halves, three weight stages
// and three blend stages. Reset is synchronous: it empties the pipeline and
// sets the segment count to 100. A full stage holds while the stage after it
// is full and stalled, empty stages fill behind it, and req_ch.ready falls
// only when all nine stages hold a beat.
// ----------------------------------------------------------------------------
`include "bezier_point_sampler_assert.svh"

module bezier_point_sampler (
   input logic      clock,
   input logic      reset,
   bzs_req_if.sink  req_ch,
   bzs_rsp_if.source rsp_ch,
   bzs_csr_if.sink  csr_ch
);
   import bzs_pkg::*;

   logic [CNT_WIDTH-1:0] segment_count_ff, segment_count_in;
   logic [CNT_WIDTH-1:0] cnt_eff;
   logic [CNT_WIDTH-1:0] idx1_in, idx1_ff, cnt1_ff;

   stage_en_type en;
   logic [NUM_STAGES-1:0] v_in, v_ff;

   points_type pts_in;
   points_type pts_ff [ST_WT+1];

   logic [T_FRAC_BITS-1:0] t;
   weights_type            weights;
   coord_type              point_x, point_y;

   assign csr_ch.ready     = 1'b1;
   assign segment_count_in = (csr_ch.valid) ? csr_ch.data : segment_count_ff;

   // A count of zero behaves as one; indexes past the end take the last sample.
   assign cnt_eff = (segment_count_ff == '0) ? CNT_WIDTH'(1) : segment_count_ff;
   assign idx1_in = (req_ch.sample_index >= cnt_eff) ? cnt_eff - CNT_WIDTH'(1)
                                                     : req_ch.sample_index;

   assign pts_in.operation    = req_ch.operation;
   assign pts_in.start_x      = req_ch.start_x;
   assign pts_in.start_y      = req_ch.start_y;
   assign pts_in.end_x        = req_ch.end_x;
   assign pts_in.end_y        = req_ch.end_y;
   assign pts_in.handle_one_x = req_ch.handle_one_x;
   assign pts_in.handle_one_y = req_ch.handle_one_y;
   assign pts_in.handle_two_x = req_ch.handle_two_x;
   assign pts_in.handle_two_y = req_ch.handle_two_y;

   always_comb begin
      en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = req_ch.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   assign req_ch.ready = en[ST_CLAMP];

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_count_ff <= CNT_RESET;
         v_ff             <= '0;
      end else begin
         segment_count_ff <= segment_count_in;
         v_ff             <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_CLAMP]) begin
         idx1_ff   <= idx1_in;
         cnt1_ff   <= cnt_eff;
         pts_ff[0] <= pts_in;
      end
      for (int k = 1; k <= ST_WT; k++) begin
         if (en[k]) begin
            pts_ff[k] <= pts_ff[k-1];
         end
      end
   end

   bzs_divider u_divider (
      .clock (clock),
      .en    (en),
      .idx   (idx1_ff),
      .cnt   (cnt1_ff),
      .t     (t)
   );

   bzs_weight u_weight (
      .clock     (clock),
      .en        (en),
      .t         (t),
      .operation (pts_ff[ST_SQ].operation),
      .weights   (weights)
   );

   bzs_blend u_blend_x (
      .clock        (clock),
      .en           (en),
      .weights      (weights),
      .start_c      (pts_ff[ST_WT].start_x),
      .handle_one_c (pts_ff[ST_WT].handle_one_x),
      .handle_two_c (pts_ff[ST_WT].handle_two_x),
      .end_c        (pts_ff[ST_WT].end_x),
      .point        (point_x)
   );

   bzs_blend u_blend_y (
      .clock        (clock),
      .en           (en),
      .weights      (weights),
      .start_c      (pts_ff[ST_WT].start_y),
      .handle_one_c (pts_ff[ST_WT].handle_one_y),
      .handle_two_c (pts_ff[ST_WT].handle_two_y),
      .end_c        (pts_ff[ST_WT].end_y),
      .point        (point_y)
   );

   assign rsp_ch.valid   = v_ff[ST_OUT];
   assign rsp_ch.point_x = point_x;
   assign rsp_ch.point_y = point_y;

   `BZS_ASSERT_SAME(a_full_when_blocked, clock, reset, !req_ch.ready, &v_ff)
   `BZS_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, v_ff[ST_CLAMP])
   `BZS_ASSERT_SAME(a_index_clamped, clock, reset, v_ff[ST_CLAMP], idx1_ff < cnt1_ff)

endmodule
